### hw/rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants, register indexes, sequencer states and control types of
// the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int STEP_BITS       = 20;
    localparam int PHASE_INT_BITS  = 5;
    localparam int MAX_RUN         = 16;
    localparam int RUN_CNT_BITS    = $clog2(MAX_RUN);
    localparam int CFG_INDEX_BITS  = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RESAMPLE_ENABLE = 1'b0,
        CFG_STEP_RATIO      = 1'b1
    } lir_cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CHECK,
        ST_EMIT,
        ST_FINISH
    } lir_state_t;

    typedef struct packed {
        logic load_diff;
        logic mul_en;
    } lir_unit_ctl_t;

endpackage

### hw/rtl/lir_interp_unit.sv
// ----------------------------------------------------------------------------
// lir_interp_unit
// Shared interpolation datapath: difference register, one registered
// multiplier and the final add with a flooring shift.
// ----------------------------------------------------------------------------
module lir_interp_unit
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  lir_unit_ctl_t          ctl,
    input  logic [SAMPLE_BITS-1:0] x_sample,
    input  logic [SAMPLE_BITS-1:0] p_sample,
    input  logic [FRAC_BITS-1:0]   phase_frac,
    output logic [SAMPLE_BITS-1:0] y_sample
);

    localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;

    logic signed [SAMPLE_BITS:0]   diff_reg;
    logic signed [SAMPLE_BITS:0]   diff_next;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [PROD_BITS-1:0]   prod_shifted;

    assign diff_next = $signed({x_sample[SAMPLE_BITS-1], x_sample})
                     - $signed({p_sample[SAMPLE_BITS-1], p_sample});
    assign prod_next = diff_reg * $signed({1'b0, phase_frac});

    always_ff @(posedge clk)
    begin
        if (ctl.load_diff)
        begin
            diff_reg <= diff_next;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // The arithmetic shift floors; the true result lies between the two
    // samples, so the low bits of the sum are exact.
    assign prod_shifted = prod_reg >>> FRAC_BITS;
    assign y_sample     = p_sample + prod_shifted[SAMPLE_BITS-1:0];

endmodule

### hw/rtl/lir_ctrl.sv
// ----------------------------------------------------------------------------
// lir_ctrl
// Sequencer of the resampler: input capture, sample and phase state, run
// counter and the output word register.
// ----------------------------------------------------------------------------
module lir_ctrl
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   enable,
    input  logic [STEP_BITS-1:0]   step,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   out_last,
    output lir_unit_ctl_t          ctl,
    output logic [SAMPLE_BITS-1:0] x_sample,
    output logic [SAMPLE_BITS-1:0] p_sample,
    output logic [FRAC_BITS-1:0]   phase_frac,
    input  logic [SAMPLE_BITS-1:0] y_sample
);

    localparam int PH_W  = FRAC_BITS + PHASE_INT_BITS;
    localparam int ACC_W = ((PH_W > STEP_BITS) ? PH_W : STEP_BITS) + 1;
    localparam logic [ACC_W-1:0]        PHASE_ONE = ACC_W'(1) << FRAC_BITS;
    localparam logic [RUN_CNT_BITS-1:0] LAST_CNT  = RUN_CNT_BITS'(MAX_RUN - 1);

    lir_state_t              state_reg;
    lir_state_t              state_next;
    logic [SAMPLE_BITS-1:0]  x_reg;
    logic [SAMPLE_BITS-1:0]  prev_reg;
    logic                    have_prev_reg;
    logic [ACC_W-1:0]        phase_reg;
    logic [RUN_CNT_BITS-1:0] cnt_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_sample_reg;
    logic                    out_last_reg;

    logic                    accept;
    logic                    out_free;
    logic                    phase_below_one;
    logic [ACC_W-1:0]        phase_sum;
    logic [ACC_W-1:0]        phase_sub;
    logic [ACC_W-1:0]        phase_wrap;
    logic                    run_last;
    logic                    emit_pass;
    logic                    emit_run;
    logic                    prime;
    logic                    finish;

    assign accept          = in_valid && in_ready;
    assign out_free        = !out_valid_reg || out_ready;
    assign phase_below_one = (phase_reg >> FRAC_BITS) == '0;
    assign phase_sum       = phase_reg + ACC_W'(step);
    assign phase_sub       = phase_reg - PHASE_ONE;
    assign phase_wrap      = phase_below_one ? '0 : ACC_W'(phase_sub[PH_W-1:0]);
    assign run_last        = ((phase_sum >> FRAC_BITS) != '0) || (cnt_reg == LAST_CNT);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!enable)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!have_prev_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = phase_below_one ? ST_EMIT : ST_FINISH;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = run_last ? ST_FINISH : ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready      = 1'b0;
        ctl.load_diff = 1'b0;
        ctl.mul_en    = 1'b0;
        emit_pass     = 1'b0;
        emit_run      = 1'b0;
        prime         = 1'b0;
        finish        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DECIDE:
            begin
                emit_pass     = !enable && out_free;
                prime         = enable && !have_prev_reg;
                ctl.load_diff = enable && have_prev_reg;
            end
            ST_CHECK:
            begin
                ctl.mul_en = phase_below_one;
            end
            ST_EMIT:
            begin
                emit_run = out_free;
            end
            ST_FINISH:
            begin
                finish = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (prime || finish)
            begin
                prev_reg <= x_reg;
            end
            if (prime)
            begin
                have_prev_reg <= 1'b1;
            end
            if (emit_run)
            begin
                phase_reg <= phase_sum;
            end
            else if (finish)
            begin
                phase_reg <= phase_wrap;
            end
            if (ctl.load_diff)
            begin
                cnt_reg <= '0;
            end
            else if (emit_run)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (emit_pass || emit_run)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= in_sample;
        end
        if (emit_pass)
        begin
            out_sample_reg <= x_reg;
            out_last_reg   <= 1'b1;
        end
        else if (emit_run)
        begin
            out_sample_reg <= y_sample;
            out_last_reg   <= run_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;
    assign x_sample   = x_reg;
    assign p_sample   = prev_reg;
    assign phase_frac = phase_reg[FRAC_BITS-1:0];

    // A word is only interpolated while the phase is below one.
    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> phase_below_one)
        else $error("interpolation with phase at or above one");

    // The final word of a run hands over to the phase wrap.
    a_last_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_run && run_last) |=> (state_reg == ST_FINISH))
        else $error("run did not close after its last word");

    // Once primed, the stored sample stays valid until reset.
    a_prev_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(have_prev_reg))
        else $error("stored sample lost without reset");

    // Passthrough leaves the interpolation phase untouched.
    a_pass_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && !enable) |=> $stable(phase_reg))
        else $error("passthrough changed the phase");

endmodule

### hw/rtl/linear_interp_resampler_top.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Linear interpolation sample-rate converter for a mono stream, with a
// passthrough mode and a configuration write channel.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Content
//  s_axis    in         tvalid / tready        one input sample per word
//  m_axis    out        tvalid / tready        one result sample, tlast ends run
//  cfg       in         cfg_valid / cfg_ready  register index and write data
//
// A passthrough word goes through the decide state to the output register;
// a priming word is only stored as the previous sample. In resample mode a
// word loads the difference (decide), then per result multiplies (check) and
// adds (emit), then wraps the phase, also when no result is due; 0 to 16
// results share the one multiplier. Reset clears the stored sample, the
// phase and all handshake state. A stalled m_axis holds the sequencer until
// the output register is free; s_axis is ready only between words.
// ----------------------------------------------------------------------------
module linear_interp_resampler_top
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [TDATA_BITS-1:0]     s_axis_tdata,   // sample_in
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [TDATA_BITS-1:0]     m_axis_tdata,   // sample_out
    output logic                      m_axis_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [STEP_BITS-1:0]      cfg_data
);

    logic                   enable_reg;
    logic [STEP_BITS-1:0]   step_reg;
    lir_unit_ctl_t          unit_ctl;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] p_sample;
    logic [FRAC_BITS-1:0]   phase_frac;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic [SAMPLE_BITS-1:0] out_sample;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            step_reg   <= STEP_BITS'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RESAMPLE_ENABLE: enable_reg <= cfg_data[0];
                CFG_STEP_RATIO:      step_reg   <= cfg_data;
                default:             enable_reg <= enable_reg;
            endcase
        end
    end

    lir_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (enable_reg),
        .step       (step_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (out_sample),
        .out_last   (m_axis_tlast),
        .ctl        (unit_ctl),
        .x_sample   (x_sample),
        .p_sample   (p_sample),
        .phase_frac (phase_frac),
        .y_sample   (y_sample)
    );

    lir_interp_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .clk        (clk),
        .ctl        (unit_ctl),
        .x_sample   (x_sample),
        .p_sample   (p_sample),
        .phase_frac (phase_frac),
        .y_sample   (y_sample)
    );

    assign m_axis_tdata = TDATA_BITS'(out_sample);

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear interpolation resampler. A short table of
// directed rows (register writes and samples) is followed by random phases.
// Each accepted input word is run through a local interpolation predictor. Each
// output word is compared with the oldest predicted word, sample and tlast
// separately. Registers are only written once the block has drained.
// ----------------------------------------------------------------------------
module testbench;
    import lir_pkg::*;

    localparam int SB             = SAMPLE_BITS_DEF;
    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int ONE            = 1 << FRAC;
    localparam int PHASE_BITS     = FRAC + PHASE_INT_BITS;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DIRECTED_ROWS  = 24;
    localparam int RANDOM_CHUNKS  = 4;
    localparam int CHUNK_WORDS    = 7;

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 last;
    } out_word_t;

    typedef enum {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        bit        en;
        int        step;
        int        sample;
        bit        typed;
        int        exp_count;
        int        exp_sample;
    } stim_row_t;

    logic           clk           = 1'b0;
    logic           rst_n         = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [SB-1:0]  s_axis_tdata  = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [SB-1:0]  m_axis_tdata;
    logic           m_axis_tlast;
    logic           cfg_valid     = 1'b0;
    logic           cfg_ready;
    lir_cfg_index_t cfg_index     = CFG_RESAMPLE_ENABLE;
    logic [STEP_BITS-1:0] cfg_data = '0;

    // Predictor state and its copy of the registers.
    bit                   mdl_enable;
    int unsigned          mdl_step;
    logic signed [SB-1:0] mdl_prev;
    bit                   mdl_have_prev;
    int unsigned          mdl_phase;

    out_word_t pending_out[$];
    int        mismatch_count = 0;
    int        source_idle_pct;
    int        sink_idle_pct;
    int        hold_token;
    int        hold_seen      = 0;
    int        hold_left      = 0;
    int        quiet_cycles   = 0;

    // Directed rows: passthrough at the extremes after reset, priming, the
    // largest and smallest legal steps, a zero and a tiny step, and a return
    // to passthrough in the middle of a resampled stream.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, 1'b0, 0,      0,        1'b1, 1, 0},
        '{ROW_SAMPLE, 1'b0, 0,      8388607,  1'b1, 1, 8388607},
        '{ROW_SAMPLE, 1'b0, 0,      -8388608, 1'b1, 1, -8388608},
        '{ROW_SAMPLE, 1'b0, 0,      -1,       1'b1, 1, -1},
        '{ROW_CONFIG, 1'b1, 65536,  0,        1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      -8388608, 1'b1, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      8388607,  1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      -8388608, 1'b0, 0, 0},
        '{ROW_CONFIG, 1'b1, 983040, 0,        1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      1000,     1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      -1000,    1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      77,       1'b0, 0, 0},
        '{ROW_CONFIG, 1'b1, 4096,   0,        1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      8388607,  1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      -8388608, 1'b0, 0, 0},
        '{ROW_CONFIG, 1'b1, 0,      0,        1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      12345,    1'b0, 0, 0},
        '{ROW_CONFIG, 1'b1, 1,      0,        1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      -4242,    1'b0, 0, 0},
        '{ROW_CONFIG, 1'b0, 65536,  0,        1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      5,        1'b1, 1, 5},
        '{ROW_CONFIG, 1'b1, 32768,  0,        1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      8388607,  1'b0, 0, 0},
        '{ROW_SAMPLE, 1'b0, 0,      0,        1'b0, 0, 0}
    };

    linear_interp_resampler_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Appends one expected word behind those already waiting.
    function automatic void queue_word(input out_word_t w);
        pending_out = {pending_out, w};
    endfunction

    // Works out the words that one accepted input sample produces and, when
    // asked, queues them as expected output.
    function automatic void predict_sample(input logic signed [SB-1:0] x, input bit keep);
        out_word_t run_words [MAX_RUN];
        longint    diff;
        longint    prod;
        int        n;
        n = 0;
        if (!mdl_enable) begin
            if (keep)
                queue_word('{sample: x, last: 1'b1});
            return;
        end
        if (!mdl_have_prev) begin
            mdl_prev      = x;
            mdl_have_prev = 1'b1;
            return;
        end
        diff = longint'(x) - longint'(mdl_prev);
        while (mdl_phase < ONE && n < MAX_RUN) begin
            prod = diff * longint'(mdl_phase);
            run_words[n].sample = SB'(longint'(mdl_prev) + (prod >>> FRAC));
            run_words[n].last   = 1'b0;
            n++;
            mdl_phase += mdl_step;
        end
        if (n > 0)
            run_words[n-1].last = 1'b1;
        if (keep)
            for (int i = 0; i < n; i++)
                queue_word(run_words[i]);
        mdl_phase = (mdl_phase >= ONE) ? mdl_phase - ONE : 0;
        mdl_phase &= (1 << PHASE_BITS) - 1;
        mdl_prev  = x;
    endfunction

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(9))
            0: return {1'b0, {(SB-1){1'b1}}};
            1: return {1'b1, {(SB-1){1'b0}}};
            2: return SB'($urandom_range(15));
            3: return SB'(-int'($urandom_range(16)));
            default: return SB'($urandom());
        endcase
    endfunction

    function automatic logic [STEP_BITS-1:0] pick_step();
        case ($urandom_range(9))
            0, 1, 2, 3: return STEP_BITS'($urandom_range(65536, 4096));
            4, 5, 6:    return STEP_BITS'($urandom_range(262144, 65536));
            7:          return STEP_BITS'($urandom_range(983040, 262144));
            8:          return STEP_BITS'($urandom());
            default:
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return STEP_BITS'(4096);
                    2:       return STEP_BITS'(983040);
                    default: return '1;
                endcase
        endcase
    endfunction

    // Offers one sample word and returns at the edge where it is taken.
    task automatic send_word(input logic [SB-1:0] d, input bit keep);
        if ($urandom_range(99) < source_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < source_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge clk); while (!s_axis_tready);
        predict_sample(d, keep);
    endtask

    // Stops offering, waits for every expected word, then gives a word that
    // produces nothing time to leave the sequencer.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input bit en, input logic [STEP_BITS-1:0] step);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RESAMPLE_ENABLE;
        cfg_data  <= {{(STEP_BITS-1){1'b0}}, en};
        do @(posedge clk); while (!cfg_ready);
        mdl_enable = en;
        cfg_index <= CFG_STEP_RATIO;
        cfg_data  <= step;
        do @(posedge clk); while (!cfg_ready);
        mdl_step = step;
        cfg_valid <= 1'b0;
    endtask

    // Output side: checks each word taken and decides tready for the next edge.
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_out.size() == 0)
                report_mismatch("unexpected word", $signed(m_axis_tdata), 0);
            else begin
                out_word_t want;
                want = pending_out.pop_front();
                if (m_axis_tdata !== want.sample)
                    report_mismatch("sample_out", $signed(m_axis_tdata), want.sample);
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", m_axis_tlast, want.last);
            end
        end
        if (hold_seen != hold_token) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("linear_interp_resampler_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        mdl_enable      = 1'b0;
        mdl_step        = ONE;
        mdl_prev        = '0;
        mdl_have_prev   = 1'b0;
        mdl_phase       = 0;
        hold_token      = 0;
        source_idle_pct = 22;
        sink_idle_pct   = 61;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CONFIG)
                configure(directed_rows[r].en, STEP_BITS'(directed_rows[r].step));
            else begin
                send_word(SB'(directed_rows[r].sample), !directed_rows[r].typed);
                if (directed_rows[r].typed)
                    for (int k = 0; k < directed_rows[r].exp_count; k++)
                        queue_word('{sample: SB'(directed_rows[r].exp_sample),
                                     last: 1'b1});
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            source_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 61 : 0;
            sink_idle_pct   = (phase == 0) ? 61 : (phase == 1) ? 22 : 0;
            for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
                configure($urandom_range(4) != 0, pick_step());
                // A long output stall while words keep coming fills the block.
                if (phase == 0 && chunk == 1)
                    hold_token++;
                for (int w = 0; w < CHUNK_WORDS; w++) begin
                    if (phase == 1 && chunk == 2 && w == CHUNK_WORDS / 2)
                        settle();
                    send_word(pick_sample(), 1'b1);
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("linear_interp_resampler_top: match");
        else
            $display("linear_interp_resampler_top: mismatch");
        $finish;
    end

endmodule
